@@ hw/rtl/rgbblur_pkg.sv @@
// Shared types and constants for the RGB555 five-point blur.
// Used by the column control, the stencil, the top level and the testbench; depends on nothing.
`default_nettype none

package rgbblur_pkg;

    // Geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int BLOCK_LANES = 8;    // power of two, lane taken from the low column bits
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = 11;
    localparam int LINE_WIDTH_RESET = 640;

    // Pixel format
    localparam int PIX_W       = 16;
    localparam int OUT_W       = 15;
    localparam int CHAN_W      = 5;
    localparam int NUM_CHAN    = 3;
    localparam int GREEN_SHIFT = 5;
    localparam int BLUE_SHIFT  = 10;
    localparam int AVG_SHIFT   = 3;
    localparam int SUM_W       = CHAN_W + AVG_SHIFT;   // 8 * 31 fits

    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [OUT_W-1:0]   rgb_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [WIDTH_W-1:0] width_t;

    localparam col_t LANE_MASK = col_t'(BLOCK_LANES - 1);

    // Position of one pixel within the frame
    typedef struct packed {
        col_t col;
        logic first_row;
    } col_info_t;

endpackage

`default_nettype wire

@@ hw/rtl/rgbblur_line_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Holds the blurred row above; no reset, contents undefined until written.
`default_nettype none

module rgbblur_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 15
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rgbblur_col_ctrl.sv @@
// Column and first-row tracking for the incoming pixel stream.
// Depends on rgbblur_pkg.
`default_nettype none

module rgbblur_col_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  advance,
    input  wire logic                  frame_start,
    input  wire rgbblur_pkg::width_t   line_width,
    output rgbblur_pkg::col_info_t     pos
);
    import rgbblur_pkg::*;

    col_t   column_count_reg, column_count_next;
    logic   first_row_reg, first_row_next;
    width_t w_eff;
    col_t   col_cur;
    logic   first_cur;
    width_t col_inc;

    // clamp the programmed width to 1..MAX_WIDTH
    always_comb begin
        if (line_width == '0) begin
            w_eff = width_t'(1);
        end else if (line_width > width_t'(MAX_WIDTH)) begin
            w_eff = width_t'(MAX_WIDTH);
        end else begin
            w_eff = line_width;
        end
    end

    // position of this word, with frame restart and a row ended by a narrowed width
    always_comb begin
        col_cur   = frame_start ? '0   : column_count_reg;
        first_cur = frame_start ? 1'b1 : first_row_reg;
        if (width_t'(col_cur) >= w_eff) begin
            col_cur   = '0;
            first_cur = 1'b0;
        end
        pos.col       = col_cur;
        pos.first_row = first_cur;
    end

    // position after this word
    always_comb begin
        col_inc = width_t'(col_cur) + width_t'(1);
        if (col_inc >= w_eff) begin
            column_count_next = '0;
            first_row_next    = 1'b0;
        end else begin
            column_count_next = col_inc[COL_W-1:0];
            first_row_next    = first_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            first_row_reg    <= 1'b1;
        end else if (advance) begin
            column_count_reg <= column_count_next;
            first_row_reg    <= first_row_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rgbblur_calc.sv @@
// Five-point stencil on the three 5-bit channels of RGB555 pixels.
// Pure combinational; depends on rgbblur_pkg.
`default_nettype none

module rgbblur_calc (
    input  wire rgbblur_pkg::pixel_t up,
    input  wire rgbblur_pkg::pixel_t down,
    input  wire rgbblur_pkg::pixel_t left,
    input  wire rgbblur_pkg::pixel_t right,
    input  wire rgbblur_pkg::pixel_t centre,
    output rgbblur_pkg::rgb_t        res
);
    import rgbblur_pkg::*;

    // per channel: (u + d + l + r + 4c) >> 3; bit 15 of every operand dropped
    always_comb begin
        logic [SUM_W-1:0] sum;
        res = '0;
        for (int i = 0; i < NUM_CHAN; i++) begin
            sum = SUM_W'(up[i*CHAN_W +: CHAN_W])
                + SUM_W'(down[i*CHAN_W +: CHAN_W])
                + SUM_W'(left[i*CHAN_W +: CHAN_W])
                + SUM_W'(right[i*CHAN_W +: CHAN_W])
                + {SUM_W'(centre[i*CHAN_W +: CHAN_W]) << 2};
            res[i*CHAN_W +: CHAN_W] = sum[AVG_SHIFT +: CHAN_W];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rgb555_five_point_blur_top.sv @@
// In-place five-point blur of an RGB555 pixel stream.
// Pipeline: an accepted word passes the input stage, then the result register on the output.
// Throughput: one pixel per cycle unless the result sink stalls; the line store has separate
// read and write ports, read on acceptance and written as the pixel leaves the input stage,
// forwarded on a same-column hit.
// Reset: column cleared, first-row flag set, neighbour history and valid flags cleared,
// line_width set to 640; the line store is not cleared and is valid once the first row has passed.
`default_nettype none

module rgb555_five_point_blur_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: line_width
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data,
    // pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // centre_pixel[15:0], right_pixel[31:16], below_pixel[47:32],
    // up_edge_pixel[63:48], left_edge_pixel[79:64]
    input  wire logic [79:0] s_tdata,
    // frame_start[0]
    input  wire logic [0:0]  s_tuser,
    // result
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // blurred_pixel[14:0], zero pad [15]
    output logic [15:0]      m_tdata
);
    import rgbblur_pkg::*;

    width_t    line_width_reg;
    col_info_t in_pos;
    logic      in_acc, out_free, s1_adv;
    logic      fwd_hit;

    // input stage
    logic      s1_valid_reg;
    pixel_t    s1_centre_reg, s1_right_reg, s1_below_reg, s1_up_edge_reg, s1_left_edge_reg;
    col_t      s1_col_reg;
    logic      s1_first_reg;
    logic      s1_fwd_reg;
    rgb_t      s1_fwd_data_reg;

    // history and result
    rgb_t      last_blurred_reg;
    pixel_t    last_original_reg;
    logic      out_valid_reg;
    rgb_t      out_data_reg;

    rgb_t      ram_rdata;
    pixel_t    s1_up, s1_left;
    rgb_t      s1_res;

    // config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= width_t'(LINE_WIDTH_RESET);
        end else if (cfg_valid) begin
            line_width_reg <= cfg_data;
        end
    end

    // handshake: result register frees the input stage, input stage frees the port
    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign in_acc   = s_tvalid && s_tready;

    rgbblur_col_ctrl u_col_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (in_acc),
        .frame_start (s_tuser[0]),
        .line_width  (line_width_reg),
        .pos         (in_pos)
    );

    // row above: read on acceptance, written when the result leaves the input stage
    rgbblur_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (OUT_W)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (s1_res),
        .re    (in_acc),
        .raddr (in_pos.col),
        .rdata (ram_rdata)
    );

    // same column written at the same edge (one-pixel rows): forward the result
    assign fwd_hit = s1_adv && (s1_col_reg == in_pos.col);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_centre_reg    <= s_tdata[15:0];
            s1_right_reg     <= s_tdata[31:16];
            s1_below_reg     <= s_tdata[47:32];
            s1_up_edge_reg   <= s_tdata[63:48];
            s1_left_edge_reg <= s_tdata[79:64];
            s1_col_reg       <= in_pos.col;
            s1_first_reg     <= in_pos.first_row;
            s1_fwd_reg       <= fwd_hit;
            s1_fwd_data_reg  <= s1_res;
        end
    end

    // operand selection
    always_comb begin
        if (s1_first_reg) begin
            s1_up = s1_up_edge_reg;
        end else if (s1_fwd_reg) begin
            s1_up = {1'b0, s1_fwd_data_reg};
        end else begin
            s1_up = {1'b0, ram_rdata};
        end

        if (s1_col_reg == '0) begin
            s1_left = s1_left_edge_reg;
        end else if ((s1_col_reg & LANE_MASK) == '0) begin
            s1_left = {1'b0, last_blurred_reg};
        end else begin
            s1_left = last_original_reg;
        end
    end

    rgbblur_calc u_calc (
        .up     (s1_up),
        .down   (s1_below_reg),
        .left   (s1_left),
        .right  (s1_right_reg),
        .centre (s1_centre_reg),
        .res    (s1_res)
    );

    // neighbour history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_blurred_reg  <= '0;
            last_original_reg <= '0;
        end else if (s1_adv) begin
            last_blurred_reg  <= s1_res;
            last_original_reg <= s1_centre_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            out_data_reg <= s1_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule

`default_nettype wire

@@ hw/rtl/rgbblur_chk.sv @@
// Port-level checks for rgb555_five_point_blur_top, attached by bind.
// Depends only on the top-level ports.
`default_nettype none

module rgbblur_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // result pixels never carry bit 15
    a_top_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[15])
        else $error("bit 15 set in result word");

    // an accepted word is delivered through the input stage and the result register when the sink is ready
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("accepted word not delivered");

    // no invented words: idle input with a ready sink drains the input stage and then the result register
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!(s_tvalid && s_tready) && m_tready) ##1 (!(s_tvalid && s_tready) && m_tready)
        |=> !m_tvalid)
        else $error("result word without an input word");

endmodule

bind rgb555_five_point_blur_top rgbblur_chk u_rgbblur_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for rgb555_five_point_blur_top: drives pixel words and
// line_width writes, predicts each blurred pixel and checks the result stream.
// Depends on rgbblur_pkg and the top-level RTL only.
`default_nettype none

module tb_top;
    import rgbblur_pkg::*;

    localparam int CHAN_MASK  = (1 << CHAN_W) - 1;
    localparam int IDLE_PCT   = 29;
    localparam int HOLD_LEN   = 300;
    localparam int HOLD_AFTER = 400;

    typedef struct {
        pixel_t centre;
        pixel_t right_px;
        pixel_t below;
        pixel_t up_edge;
        pixel_t left_edge;
        logic   frame_start;
    } pix_word_t;

    // DUT connections; the driven ones are known from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    width_t      cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;

    // stimulus and checking state
    pix_word_t pending_pixels[$];
    rgb_t      blurred_due[$];
    pix_word_t next_word;
    bit        word_taken  = 1'b0;
    bit        calm        = 1'b0;
    bit        hold_done   = 1'b0;
    int        hold_cycles = 0;
    int        words_in    = 0;
    int        words_out   = 0;
    int        fail_count  = 0;
    int        widths_run  = 0;

    // predictor state
    int        line_width_q = LINE_WIDTH_RESET;
    rgb_t      row_above[MAX_WIDTH];
    rgb_t      prev_blurred = '0;
    pixel_t    prev_orig    = '0;
    int        col_pos      = 0;
    bit        first_row    = 1'b1;

    rgb555_five_point_blur_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock and reset
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // five-point average of each 5-bit channel; bit 15 of every operand drops out
    function automatic rgb_t blur_pixel(pixel_t up_px, pixel_t down_px, pixel_t left_px,
                                        pixel_t right_px, pixel_t centre_px);
        rgb_t res;
        int   sh;
        int   sum;
        res = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            sh  = ch * CHAN_W;
            sum = ((up_px >> sh) & CHAN_MASK) + ((down_px >> sh) & CHAN_MASK)
                + ((left_px >> sh) & CHAN_MASK) + ((right_px >> sh) & CHAN_MASK)
                + (((centre_px >> sh) & CHAN_MASK) << 2);
            res = res | rgb_t'(((sum >> AVG_SHIFT) & CHAN_MASK) << sh);
        end
        return res;
    endfunction

    // advance the frame position for one accepted word and queue its blurred pixel
    task automatic predict_blur(input pix_word_t w);
        int     eff;
        pixel_t up_px;
        pixel_t left_px;
        rgb_t   res;
        eff = (line_width_q == 0) ? 1 : ((line_width_q > MAX_WIDTH) ? MAX_WIDTH : line_width_q);
        if (w.frame_start) begin
            col_pos   = 0;
            first_row = 1'b1;
        end
        // width narrowed under the current column ends the row
        if (col_pos >= eff) begin
            col_pos   = 0;
            first_row = 1'b0;
        end
        up_px = first_row ? w.up_edge : {1'b0, row_above[col_pos]};
        if (col_pos == 0)
            left_px = w.left_edge;
        else if ((col_pos % BLOCK_LANES) == 0)
            left_px = {1'b0, prev_blurred};
        else
            left_px = prev_orig;
        res = blur_pixel(up_px, w.below, left_px, w.right_px, w.centre);
        row_above[col_pos] = res;
        prev_blurred = res;
        prev_orig    = w.centre;
        col_pos++;
        if (col_pos >= eff) begin
            col_pos   = 0;
            first_row = 1'b0;
        end
        blurred_due.push_back(res);
    endtask

    // pixel driver: new word at the falling edge once the previous one has gone
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (pending_pixels.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_word = pending_pixels.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_word.left_edge, next_word.up_edge, next_word.below,
                             next_word.right_px, next_word.centre};
                s_tuser  <= next_word.frame_start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        word_taken = 1'b0;
    end

    // result receiver: random stalls, plus one long hold-off to back up the input
    always @(negedge aclk) begin
        if (hold_cycles != 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else if (!hold_done && words_in >= HOLD_AFTER) begin
            hold_done   = 1'b1;
            hold_cycles = HOLD_LEN;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: check results, then predict from the words accepted at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                words_out++;
                if (blurred_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 20)
                        $display("%0t: unexpected result word, expected none, actual %h",
                                 $time, m_tdata);
                end else if (m_tdata !== {1'b0, blurred_due[0]}) begin
                    fail_count++;
                    if (fail_count <= 20)
                        $display("%0t: blurred_pixel mismatch, expected %h, actual %h",
                                 $time, {1'b0, blurred_due[0]}, m_tdata);
                    void'(blurred_due.pop_front());
                end else begin
                    void'(blurred_due.pop_front());
                end
            end
            if (cfg_valid && cfg_ready)
                line_width_q = cfg_data;
            if (s_tvalid && s_tready) begin
                predict_blur('{s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                               s_tdata[63:48], s_tdata[79:64], s_tuser[0]});
                words_in++;
                word_taken = 1'b1;
            end
        end
    end

    function automatic pixel_t rand_pixel();
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4:       return pixel_t'(CHAN_MASK << ($urandom_range(0, NUM_CHAN - 1) * CHAN_W));
            default: return pixel_t'($urandom);
        endcase
    endfunction

    task automatic push_pixel(input pixel_t c, input pixel_t r, input pixel_t b,
                              input pixel_t u, input pixel_t l, input logic fs);
        pending_pixels.push_back('{c, r, b, u, l, fs});
    endtask

    // random words; frame starts now and then break a row part way through
    task automatic push_random(input int n, input bit fs_first);
        for (int i = 0; i < n; i++)
            push_pixel(rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel(),
                       (i == 0 && fs_first) || ($urandom_range(0, 149) == 0));
    endtask

    // block idle: everything sent and every result back
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || s_tvalid || blurred_due.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_width(input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= width_t'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // new width, then a run of random words; a frame start avoids stale line store reads
    task automatic run_phase(input int width, input int len, input bit fs_first,
                             input bit quiet);
        wait_drained();
        write_width(width);
        calm = quiet;
        widths_run++;
        push_random(len, fs_first);
    endtask

    // stimulus
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // directed words at the reset width, first row so 'up' comes from the edge field
        push_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
        push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        push_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        push_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        push_pixel(16'h001F, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        push_pixel(16'h03E0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        push_pixel(16'h7C00, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0);
        push_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        // column 8 takes the blurred previous pixel, column 9 the original one
        push_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        push_pixel(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0);
        push_random(7, 1'b0);
        // frame start part way through a row
        push_pixel(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF, 1'b1);
        push_random(3, 1'b0);

        // widths: below range, minimum, lane edges, clamped, maximum
        run_phase(0,    120,  1'b1, 1'b0);
        run_phase(1,    60,   1'b1, 1'b0);
        run_phase(9,    120,  1'b1, 1'b0);
        run_phase(8,    120,  1'b1, 1'b0);
        // narrow the width while part way through the second row
        run_phase(17,   30,   1'b1, 1'b0);
        run_phase(5,    80,   1'b0, 1'b0);
        run_phase(3,    100,  1'b1, 1'b0);
        run_phase(2047, 120,  1'b1, 1'b0);
        run_phase(1024, 1040, 1'b1, 1'b1);
        run_phase($urandom_range(2, 40), 150, 1'b1, 1'b0);

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Ran %0d pixel words and %0d results over %0d line widths,", words_in,
                 words_out, widths_run + 1);
        $display("including clamped widths, a mid-row narrowing and a long output stall.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ rgb555_five_point_blur_top.f @@
hw/rtl/rgbblur_pkg.sv
hw/rtl/rgbblur_line_ram.sv
hw/rtl/rgbblur_col_ctrl.sv
hw/rtl/rgbblur_calc.sv
hw/rtl/rgb555_five_point_blur_top.sv
hw/rtl/rgbblur_chk.sv
dv/tb_top.sv
